FILE: hw/rtl/lcats_pkg.sv
`default_nettype none

package lcats_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARE_COUNT      = 2'd0;
    localparam logic [1:0] CFG_RUN_COUNT       = 2'd1;
    localparam logic [1:0] CFG_SPIKE_THRESHOLD = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int CNT_W  = 5;    // sample count registers
    localparam int THR_W  = 24;   // spike threshold
    localparam int INV_W  = 32;   // invalid sample counter
    localparam int SPK_W  = 32;   // spike counter
    localparam int AVG_W  = 24;   // average field
    localparam int NET_W  = 25;   // net and change fields
    localparam int DIFF_W = 38;   // exact difference of two means of up to 37 bits

    localparam logic [CNT_W-1:0] TARE_COUNT_RST = 5'd10;
    localparam logic [CNT_W-1:0] RUN_COUNT_RST  = 5'd3;
    localparam logic [THR_W-1:0] SPIKE_THR_RST  = 24'd50000;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DIFF,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lcats_front.sv
`default_nettype none

module lcats_front
    import lcats_pkg::*;
#(
    parameter int CODE_BITS = 24,
    parameter int SUM_W     = 29,
    parameter int CNT_CAP   = 16,
    localparam int ENTRY_W  = 1 + CNT_W + SUM_W + INV_W
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CODE_BITS-1:0] sample_code,
    input  wire logic                 sample_valid,
    input  wire logic [CNT_W-1:0]     tare_count,
    input  wire logic [CNT_W-1:0]     run_count,
    input  wire fifo_status_t         fifo_st,
    output logic                      push,
    output logic [ENTRY_W-1:0]        push_data
);

    localparam logic [CNT_W-1:0] CNT_CAP_V = CNT_W'(CNT_CAP);

    logic                    taring_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        seen_reg;
    logic [INV_W-1:0]        invalid_reg;

    logic                    accept;
    logic signed [SUM_W-1:0] code_ext;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        seen_next;
    logic [CNT_W-1:0]        count_raw;
    logic [CNT_W-1:0]        count;
    logic                    fire;

    assign in_stall = fifo_st.full;
    assign accept   = in_valid && !fifo_st.full;

    assign code_ext  = SUM_W'($signed(sample_code));
    assign sum_next  = sum_reg + code_ext;
    assign seen_next = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    assign count_raw = taring_reg ? tare_count : run_count;

    always_comb
    begin
        if (count_raw == '0)
            count = CNT_W'(1);
        else if (count_raw > CNT_CAP_V)
            count = CNT_CAP_V;
        else
            count = count_raw;
    end

    assign fire      = accept && sample_valid && (seen_next >= count);
    assign push      = fire;
    // invalid count travels with the job so later bad reads do not leak into it
    assign push_data = {taring_reg, count, sum_next, invalid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taring_reg  <= 1'b1;
            sum_reg     <= '0;
            seen_reg    <= '0;
            invalid_reg <= '0;
        end
        else if (accept)
        begin
            if (!sample_valid)
            begin
                if (invalid_reg != '1)
                    invalid_reg <= invalid_reg + 1'b1;
            end
            else if (fire)
            begin
                taring_reg <= 1'b0;
                sum_reg    <= '0;
                seen_reg   <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                seen_reg <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcats_fifo.sv
`default_nettype none

module lcats_fifo
    import lcats_pkg::*;
#(
    parameter int WIDTH = 67,
    parameter int DEPTH = 2
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output fifo_status_t          status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;

    logic do_push;
    logic do_pop;

    assign status.full  = (level_reg == FULL_LVL);
    assign status.empty = (level_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                level_reg <= level_reg + 1'b1;
            else if (do_pop && !do_push)
                level_reg <= level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcats_div.sv
`default_nettype none

module lcats_div
    import lcats_pkg::*;
#(
    parameter int SUM_W = 29,
    parameter int Q_W   = 24
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    output logic                         done,
    output logic signed [Q_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    // acc_reg shifts the dividend magnitude out at the top and the quotient in at the bottom
    logic [SUM_W-1:0]      acc_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      dvs_reg;
    logic                  neg_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  run_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic signed [Q_W-1:0] quo_reg;

    logic [SUM_W-1:0]      mag_in;
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        trial_diff;
    logic                  ge;
    logic [SUM_W-1:0]      signed_q;

    assign mag_in     = dividend[SUM_W-1] ? unsigned'(-dividend) : unsigned'(dividend);
    assign trial      = {rem_reg, acc_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign ge         = (trial >= {1'b0, dvs_reg});
    assign signed_q   = neg_reg ? (~acc_reg + 1'b1) : acc_reg;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= mag_in;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
        if (fin_reg)
            quo_reg <= signed_q[Q_W-1:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcats_back.sv
`default_nettype none

module lcats_back
    import lcats_pkg::*;
#(
    parameter int SUM_W     = 29,
    localparam int ENTRY_W  = 1 + CNT_W + SUM_W + INV_W
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fifo_status_t        fifo_st,
    input  wire logic [ENTRY_W-1:0]  head,
    output logic                     pop,
    input  wire logic [THR_W-1:0]    spike_threshold,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     is_offset,
    output logic signed [AVG_W-1:0]  average,
    output logic signed [NET_W-1:0]  net_value,
    output logic signed [NET_W-1:0]  change,
    output logic                     spike,
    output logic [SPK_W-1:0]         spike_total,
    output logic [INV_W-1:0]         invalid_total
);

    back_state_t state_reg;
    back_state_t state_next;

    logic                          head_off;
    logic [CNT_W-1:0]              head_cnt;
    logic signed [SUM_W-1:0]       head_sum;
    logic [INV_W-1:0]              head_inv;

    // a mean may be wider than a code when the count drops during a sum
    logic                          div_done;
    logic signed [SUM_W-1:0]       div_quo;

    logic                          is_off_reg;
    logic [INV_W-1:0]              inv_snap_reg;
    logic signed [SUM_W-1:0]       tare_off_reg;
    logic signed [SUM_W-1:0]       prev_avg_reg;
    logic [AVG_W-1:0]              avg_reg;
    logic [NET_W-1:0]              net_reg;
    logic [NET_W-1:0]              chg_reg;
    logic [DIFF_W-1:0]             mag_reg;
    logic [SPK_W-1:0]              spike_cnt_reg;

    logic                          out_valid_reg;
    logic                          is_offset_reg;
    logic [AVG_W-1:0]              average_reg;
    logic [NET_W-1:0]              net_value_reg;
    logic [NET_W-1:0]              change_reg;
    logic                          spike_reg;
    logic [SPK_W-1:0]              spike_total_reg;
    logic [INV_W-1:0]              invalid_total_reg;

    logic                          load_diff;
    logic                          load_out;
    logic                          out_free;
    logic signed [DIFF_W-1:0]      avg_ext;
    logic signed [DIFF_W-1:0]      off_ext;
    logic signed [DIFF_W-1:0]      prev_ext;
    logic signed [DIFF_W-1:0]      net_d;
    logic signed [DIFF_W-1:0]      chg_d;
    logic signed [DIFF_W-1:0]      nchg_d;
    logic                          spike_hit;
    logic [SPK_W-1:0]              spike_cnt_next;

    assign head_off = head[ENTRY_W-1];
    assign head_cnt = head[ENTRY_W-2 -: CNT_W];
    assign head_sum = head[INV_W +: SUM_W];
    assign head_inv = head[INV_W-1:0];

    lcats_div #(
        .SUM_W (SUM_W),
        .Q_W   (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .dividend (head_sum),
        .divisor  (head_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign avg_ext  = DIFF_W'(div_quo);
    assign off_ext  = DIFF_W'(tare_off_reg);
    assign prev_ext = DIFF_W'(prev_avg_reg);
    assign net_d    = avg_ext - off_ext;
    assign chg_d    = avg_ext - prev_ext;
    assign nchg_d   = prev_ext - avg_ext;

    assign out_free       = !out_valid_reg || !out_stall;
    assign spike_hit      = !is_off_reg && (mag_reg > DIFF_W'(spike_threshold));
    assign spike_cnt_next = spike_cnt_reg + SPK_W'(spike_hit);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_diff  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_st.empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                    state_next = BK_DIFF;
            end
            BK_DIFF:
            begin
                load_diff  = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_off_reg  <= '0;
            prev_avg_reg  <= '0;
            spike_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_diff)
            begin
                prev_avg_reg <= div_quo;
                if (is_off_reg)
                    tare_off_reg <= div_quo;
            end
            if (load_out)
                spike_cnt_reg <= spike_cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            is_off_reg   <= head_off;
            inv_snap_reg <= head_inv;
        end
        if (load_diff)
        begin
            avg_reg <= avg_ext[AVG_W-1:0];
            if (is_off_reg)
            begin
                net_reg <= '0;
                chg_reg <= '0;
                mag_reg <= '0;
            end
            else
            begin
                net_reg <= net_d[NET_W-1:0];
                chg_reg <= chg_d[NET_W-1:0];
                mag_reg <= chg_d[DIFF_W-1] ? unsigned'(nchg_d) : unsigned'(chg_d);
            end
        end
        if (load_out)
        begin
            is_offset_reg     <= is_off_reg;
            average_reg       <= avg_reg;
            net_value_reg     <= net_reg;
            change_reg        <= chg_reg;
            spike_reg         <= spike_hit;
            spike_total_reg   <= spike_cnt_next;
            invalid_total_reg <= inv_snap_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_offset     = is_offset_reg;
    assign average       = signed'(average_reg);
    assign net_value     = signed'(net_value_reg);
    assign change        = signed'(change_reg);
    assign spike         = spike_reg;
    assign spike_total   = spike_total_reg;
    assign invalid_total = invalid_total_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/load_cell_average_tare_spike_core.sv
`default_nettype none

// Load-cell averaging with tare and spike detection.
// Input channel (in_valid/in_stall): one converter code per transaction plus a
// good-read flag. Bad reads only bump a saturating counter. Good reads are
// summed; every tare_count (first mean) or run_count (later means) good reads
// produce one result transaction on the output channel (out_valid/out_stall).
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
// tare_count, 1 run_count, 2 spike_threshold. Write only while idle.
// Timing: input transactions are taken one per cycle while the two-entry job
// queue has room. Each mean goes through a one-bit-per-cycle divider, and the
// back end pops the next job only after the last result is in the output
// register, so it works on one mean at a time.
// A stalled result sits in the output register while the next mean is worked
// out; if the queue then fills, in_stall rises.
// Reset: registers return to 10 / 3 / 50000, counters and sums clear, and the
// next mean becomes the tare offset (is_offset high).

module load_cell_average_tare_spike_core
    import lcats_pkg::*;
#(
    parameter int MAX_SAMPLES = 16,
    parameter int CODE_BITS   = 24
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CODE_BITS-1:0]  sample_code,
    input  wire logic                  sample_valid,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       is_offset,
    output logic signed [AVG_W-1:0]    average,
    output logic signed [NET_W-1:0]    net_value,
    output logic signed [NET_W-1:0]    change,
    output logic                       spike,
    output logic [SPK_W-1:0]           spike_total,
    output logic [INV_W-1:0]           invalid_total
);

    // the count registers are 5 bits, so no sum ever holds more than 31 samples
    localparam int CNT_CAP = (MAX_SAMPLES > 31) ? 31 : MAX_SAMPLES;
    localparam int SUM_W   = CODE_BITS + $clog2(CNT_CAP + 1);
    localparam int ENTRY_W = 1 + CNT_W + SUM_W + INV_W;

    logic [CNT_W-1:0]   tare_count_reg;
    logic [CNT_W-1:0]   run_count_reg;
    logic [THR_W-1:0]   spike_thr_reg;

    fifo_status_t       fifo_st;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic [ENTRY_W-1:0] head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_count_reg <= TARE_COUNT_RST;
            run_count_reg  <= RUN_COUNT_RST;
            spike_thr_reg  <= SPIKE_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARE_COUNT:      tare_count_reg <= cfg_data[CNT_W-1:0];
                CFG_RUN_COUNT:       run_count_reg  <= cfg_data[CNT_W-1:0];
                CFG_SPIKE_THRESHOLD: spike_thr_reg  <= cfg_data[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    lcats_front #(
        .CODE_BITS (CODE_BITS),
        .SUM_W     (SUM_W),
        .CNT_CAP   (CNT_CAP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_code  (sample_code),
        .sample_valid (sample_valid),
        .tare_count   (tare_count_reg),
        .run_count    (run_count_reg),
        .fifo_st      (fifo_st),
        .push         (push),
        .push_data    (push_data)
    );

    lcats_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (fifo_st)
    );

    lcats_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_st         (fifo_st),
        .head            (head),
        .pop             (pop),
        .spike_threshold (spike_thr_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .is_offset       (is_offset),
        .average         (average),
        .net_value       (net_value),
        .change          (change),
        .spike           (spike),
        .spike_total     (spike_total),
        .invalid_total   (invalid_total)
    );

    a_offset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_offset |-> (net_value == '0) && (change == '0) && !spike)
        else $error("offset result carries net, change or spike");

    a_spike_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spike |-> (spike_total != '0) && !is_offset)
        else $error("spike flagged without a count");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.full |-> in_stall && !push)
        else $error("job queue overrun");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
    import lcats_pkg::*;

    localparam int CODE_W        = 24;
    localparam int SAMPLE_MAX    = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              good;
    } sample_t;

    typedef struct {
        logic                    is_offset;
        logic signed [AVG_W-1:0] average;
        logic signed [NET_W-1:0] net_value;
        logic signed [NET_W-1:0] change;
        logic                    spike;
        logic [SPK_W-1:0]        spike_total;
        logic [INV_W-1:0]        invalid_total;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CODE_W-1:0]     sample_code = '0;
    logic                  sample_valid = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_offset;
    logic signed [AVG_W-1:0] average;
    logic signed [NET_W-1:0] net_value;
    logic signed [NET_W-1:0] change;
    logic                  spike;
    logic [SPK_W-1:0]      spike_total;
    logic [INV_W-1:0]      invalid_total;

    // predictor state
    logic [CNT_W-1:0] tare_n = TARE_COUNT_RST;
    logic [CNT_W-1:0] run_n = RUN_COUNT_RST;
    logic [THR_W-1:0] spike_thr = SPIKE_THR_RST;
    logic             taring = 1'b1;
    longint           sample_sum = 0;
    int unsigned      samples_seen = 0;
    longint           tare_offset = 0;
    longint           last_mean = 0;
    logic [SPK_W-1:0] spikes_seen = '0;
    logic [INV_W-1:0] bad_reads = '0;

    sample_t  pending_samples[$];
    reading_t readings_due[$];

    int   items_queued = 0;
    int   items_taken = 0;
    int   fail_count = 0;
    int   cycle_count = 0;
    int   gap_max = 3;
    int   stall_max = 3;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;
    logic code_accepted = 1'b0;
    logic reading_taken = 1'b0;

    load_cell_average_tare_spike_core #(
        .MAX_SAMPLES (SAMPLE_MAX),
        .CODE_BITS   (CODE_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_code   (sample_code),
        .sample_valid  (sample_valid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_offset     (is_offset),
        .average       (average),
        .net_value     (net_value),
        .change        (change),
        .spike         (spike),
        .spike_total   (spike_total),
        .invalid_total (invalid_total)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // expected reading, if any, for one accepted sample
    task automatic predict_sample(input logic [CODE_W-1:0] code, input logic good);
        longint      mean;
        longint      delta;
        longint      net;
        int unsigned need;
        reading_t    r;
        if (!good)
        begin
            if (bad_reads != '1)
                bad_reads++;
            return;
        end
        sample_sum += longint'($signed(code));
        if (samples_seen < 31)
            samples_seen++;
        need = taring ? tare_n : run_n;
        if (need == 0)
            need = 1;
        else if (need > SAMPLE_MAX)
            need = SAMPLE_MAX;
        if (samples_seen < need)
            return;
        mean = sample_sum / longint'(need);
        sample_sum = 0;
        samples_seen = 0;
        r.average = mean[AVG_W-1:0];
        r.spike_total = spikes_seen;
        r.invalid_total = bad_reads;
        if (taring)
        begin
            taring = 1'b0;
            tare_offset = mean;
            last_mean = mean;
            r.is_offset = 1'b1;
            r.net_value = '0;
            r.change = '0;
            r.spike = 1'b0;
        end
        else
        begin
            net = mean - tare_offset;
            delta = mean - last_mean;
            r.spike = ((delta < 0 ? -delta : delta) > longint'(spike_thr));
            if (r.spike)
                spikes_seen++;
            last_mean = mean;
            r.is_offset = 1'b0;
            r.net_value = net[NET_W-1:0];
            r.change = delta[NET_W-1:0];
            r.spike_total = spikes_seen;
        end
        readings_due.push_back(r);
    endtask

    task automatic compare_field(input string label, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", label, want, got);
            fail_count++;
        end
    endtask

    // input side: prediction on every accepted transaction
    always @(posedge clk)
    begin
        code_accepted <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_sample(sample_code, sample_valid);
            items_taken++;
        end
    end

    always @(negedge clk)
    begin : drive_samples
        sample_t nxt;
        if (rst_n && !(in_valid && !code_accepted))
        begin
            if (pending_samples.size() != 0 && gap_left == 0)
            begin
                nxt = pending_samples.pop_front();
                sample_code <= nxt.code;
                sample_valid <= nxt.good;
                in_valid <= 1'b1;
                gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
        end
    end

    always @(posedge clk)
    begin : check_readings
        reading_t want;
        reading_taken <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result transaction with no reading expected");
                fail_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                compare_field("is_offset", want.is_offset, is_offset);
                compare_field("average", want.average, average);
                compare_field("net_value", want.net_value, net_value);
                compare_field("change", want.change, change);
                compare_field("spike", want.spike, spike);
                compare_field("spike_total", want.spike_total, spike_total);
                compare_field("invalid_total", want.invalid_total, invalid_total);
            end
        end
    end

    // receiver back-pressure, plus one long hold-off when armed
    always @(negedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (reading_taken)
            stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic queue_sample(input logic [CODE_W-1:0] code, input logic good);
        sample_t s;
        s.code = code;
        s.good = good;
        pending_samples.push_back(s);
        items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_taken != items_queued || readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TARE_COUNT:      tare_n = data[CNT_W-1:0];
            CFG_RUN_COUNT:       run_n = data[CNT_W-1:0];
            CFG_SPIKE_THRESHOLD: spike_thr = data[THR_W-1:0];
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] run_table[4];
        logic [CFG_DATA_W-1:0] thr_table[4];
        logic [CFG_DATA_W-1:0] run_data;
        logic [CFG_DATA_W-1:0] thr_data;
        logic [CODE_W-1:0]     centre;
        logic [CODE_W-1:0]     code;
        int                    spread;
        int                    sel;
        run_table = '{24'h000000, 24'hABCDF0, 24'h000001, 24'h00001F};
        thr_table = '{24'hFFFFFF, 24'd0, 24'd100, 24'd50000};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tare sum started at the largest count, then the count drops to zero
        // (taken as one) so the next good read closes a sum of all five, divided by one
        write_reg(CFG_TARE_COUNT, 24'd16);
        queue_sample(24'h000005, 1'b1);
        queue_sample(24'hFFFFFF, 1'b0);
        queue_sample(24'hFFFFF0, 1'b1);
        queue_sample(24'h000100, 1'b1);
        queue_sample(24'hFFFFFF, 1'b1);
        queue_sample(24'h800000, 1'b0);
        wait_idle();
        write_reg(CFG_TARE_COUNT, 24'hFFFFE0);
        queue_sample(24'h000003, 1'b1);
        // running means at reset count and threshold: -1/3 truncates to zero,
        // then full-scale swings both ways
        queue_sample(24'h7FFFFF, 1'b1);
        queue_sample(24'h800000, 1'b1);
        queue_sample(24'h000000, 1'b1);
        repeat (3) queue_sample(24'h7FFFFF, 1'b1);
        repeat (3) queue_sample(24'h800000, 1'b1);
        wait_idle();

        // threshold edge: a change equal to it is no spike, one more is
        write_reg(CFG_RUN_COUNT, 24'd1);
        write_reg(CFG_SPIKE_THRESHOLD, 24'd100);
        write_reg(CFG_SPARE, 24'hFFFFFF);
        queue_sample(24'h000000, 1'b1);
        queue_sample(24'h000064, 1'b1);
        queue_sample(24'hFFFFFF, 1'b1);
        queue_sample(24'h000063, 1'b1);
        wait_idle();
        write_reg(CFG_SPIKE_THRESHOLD, 24'd0);
        queue_sample(24'h000063, 1'b1);
        queue_sample(24'h000064, 1'b1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                run_data = run_table[ph];
                thr_data = thr_table[ph];
            end
            else
            begin
                sel = $urandom_range(0, 7);
                case (sel)
                    0:       run_data = {19'($urandom_range(0, 7)), 5'd0};
                    1, 7:    run_data = 24'd1;
                    2:       run_data = 24'd2;
                    3:       run_data = 24'd3;
                    4:       run_data = 24'd16;
                    5:       run_data = {19'($urandom), 5'($urandom_range(17, 31))};
                    default: run_data = 24'($urandom_range(4, 15));
                endcase
                sel = $urandom_range(0, 4);
                case (sel)
                    0:       thr_data = 24'd0;
                    1:       thr_data = 24'($urandom_range(0, 300));
                    2:       thr_data = 24'($urandom_range(40000, 80000));
                    3:       thr_data = 24'hFFFFFF;
                    default: thr_data = 24'($urandom);
                endcase
            end
            write_reg(CFG_RUN_COUNT, run_data);
            write_reg(CFG_SPIKE_THRESHOLD, thr_data);
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_TARE_COUNT, 24'($urandom));

            gap_max = 3 * $urandom_range(0, 1);
            stall_max = 3 * $urandom_range(0, 1);
            if (ph == 2)
            begin
                // back-to-back means with the output held off fill the job queue
                gap_max = 0;
                stall_max = 3;
                hold_armed = 1'b1;
            end
            else if (ph == 3)
            begin
                gap_max = 0;
                stall_max = 0;
            end

            case ($urandom_range(0, 3))
                0:       spread = 4;
                1:       spread = 200;
                2:       spread = 70000;
                default: spread = 2000000;
            endcase
            centre = 24'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    code = 24'($urandom);
                else if (sel < 9)
                    code = centre + 24'($urandom_range(0, 2 * spread)) - 24'(spread);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       code = 24'h800000;
                        1:       code = 24'h7FFFFF;
                        2:       code = 24'h000000;
                        default: code = 24'hFFFFFF;
                    endcase
                end
                queue_sample(code, $urandom_range(0, 7) != 0);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
